>>> rtl/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Types and codes shared by the page frame allocator core and its users.
// ----------------------------------------------------------------------------
package pfa_pkg;

  // operation codes
  localparam logic [2:0] OP_ALLOC  = 3'd0;
  localparam logic [2:0] OP_RETAIN = 3'd1;
  localparam logic [2:0] OP_FREE   = 3'd2;
  localparam logic [2:0] OP_QUERY  = 3'd3;
  localparam logic [2:0] OP_INIT   = 3'd4;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_OOM     = 3'd1;
  localparam logic [2:0] ST_INVALID = 3'd2;
  localparam logic [2:0] ST_DOUBLE  = 3'd3;
  localparam logic [2:0] ST_SAT     = 3'd4;

  // configuration register indexes
  localparam logic [0:0] CFG_MEMORY_BASE   = 1'd0;
  localparam logic [0:0] CFG_RESERVED_PAGES = 1'd1;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] address;
  } pfa_req_t;

  typedef struct packed {
    logic [31:0] page_address;
    logic [15:0] refs;
    logic [2:0]  status;
    logic        page_released;
    logic [12:0] free_page_count;
  } pfa_rsp_t;

endpackage

>>> rtl/page_frame_allocator_refcount_core.sv
// ----------------------------------------------------------------------------
// page_frame_allocator_refcount_core
// Physical page frame allocator: free frames in a circular queue memory,
// per-frame reference counts in a count memory, one result per request.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------
//  request | in        | in_valid_i/in_stall_o | in_data_i  (pfa_req_t)
//  result  | out       | out_valid_o/out_stall_i| out_data_o (pfa_rsp_t)
//  config  | in        | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// a request has a read and a write-back step: the transfer cycle reads the
// count and queue memories, then the execute state modifies and writes them
// back and loads the result register, which lets the next request in while
// a result waits; a held result stalls only the write-back step of the
// following request. after reset and after an initialize request the block
// sweeps both memories, in_stall_o high; configuration writes are still taken.

module page_frame_allocator_refcount_core #(
  parameter int unsigned PAGE_COUNT = 4096,
  parameter int unsigned PAGE_SHIFT = 12,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pfa_pkg::pfa_req_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pfa_pkg::pfa_rsp_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i
);

  import pfa_pkg::*;

  localparam int unsigned IW = $clog2(PAGE_COUNT);
  localparam int unsigned NW = $clog2(PAGE_COUNT + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
  localparam logic [IW-1:0] LAST_IDX = IW'(PAGE_COUNT - 1);
  localparam logic [NW-1:0] FULL_CNT = NW'(PAGE_COUNT);
  localparam logic [31:0] OFFS_MASK = 32'((64'd1 << PAGE_SHIFT) - 64'd1);

  localparam logic [1:0] S_SWEEP = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  // memories
  logic [COUNT_BITS-1:0] cnt_mem [PAGE_COUNT];
  logic [IW-1:0]         que_mem [PAGE_COUNT];

  logic [1:0]            state_q, state_d;
  logic [IW-1:0]         sweep_q, sweep_d;
  logic [NW-1:0]         held_q, held_d;
  logic [IW-1:0]         head_q, head_d;
  logic [IW-1:0]         tail_q, tail_d;
  logic [NW-1:0]         queued_q, queued_d;
  logic [31:0]           base_q;
  logic [12:0]           rsv_q;
  logic                  out_valid_q;
  pfa_rsp_t              out_q, out_d;

  logic [2:0]            op_q;
  logic [IW-1:0]         idx_q;
  logic                  addr_ok_q;
  logic [COUNT_BITS-1:0] cnt_rd_q;
  logic [IW-1:0]         que_rd_q;

  logic                  in_xfer, exec_go;
  logic [31:0]           page, offs, frame;
  logic                  addr_ok;
  logic [IW-1:0]         req_idx;

  logic                  cnt_we;
  logic [IW-1:0]         cnt_wa;
  logic [COUNT_BITS-1:0] cnt_wd;
  logic                  que_we;
  logic [IW-1:0]         que_wa;
  logic [IW-1:0]         que_wd;

  logic [COUNT_BITS-1:0] cnt_new;
  logic [NW-1:0]         held_c;

  function automatic logic [IW-1:0] wrap_next(input logic [IW-1:0] p);
    wrap_next = (p == LAST_IDX) ? '0 : p + IW'(1);
  endfunction

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign exec_go    = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // address decode ahead of the memory read
  always_comb begin
    page    = in_data_i.address & ~OFFS_MASK;
    offs    = page - base_q;
    frame   = offs >> PAGE_SHIFT;
    addr_ok = (page >= base_q) && (frame < 32'(PAGE_COUNT));
    req_idx = frame[IW-1:0];
  end

  // reserved count beyond the table acts as the whole table
  assign held_c = (32'(rsv_q) > 32'(PAGE_COUNT)) ? FULL_CNT : NW'(rsv_q);

  always_comb begin
    state_d  = state_q;
    sweep_d  = sweep_q;
    held_d   = held_q;
    head_d   = head_q;
    tail_d   = tail_q;
    queued_d = queued_q;
    out_d    = out_q;
    cnt_we   = 1'b0;
    cnt_wa   = idx_q;
    cnt_wd   = cnt_rd_q;
    que_we   = 1'b0;
    que_wa   = tail_q;
    que_wd   = idx_q;
    cnt_new  = cnt_rd_q;

    case (state_q)
      S_SWEEP: begin
        cnt_we = 1'b1;
        cnt_wa = sweep_q;
        cnt_wd = (NW'(sweep_q) < held_q) ? CNT_ONE : '0;
        que_we = (NW'(sweep_q) >= held_q);
        que_wa = IW'(NW'(sweep_q) - held_q);
        que_wd = sweep_q;
        sweep_d = sweep_q + IW'(1);
        if (sweep_q == LAST_IDX) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_d = S_IDLE;
          out_d   = '0;
          out_d.status = ST_OK;
          case (op_q)
            OP_ALLOC: begin
              if (queued_q == '0) begin
                out_d.status = ST_OOM;
              end else begin
                cnt_we   = 1'b1;
                cnt_wa   = que_rd_q;
                cnt_wd   = CNT_ONE;
                head_d   = wrap_next(head_q);
                queued_d = queued_q - NW'(1);
                out_d.page_address = base_q + (32'(que_rd_q) << PAGE_SHIFT);
                out_d.refs         = 16'd1;
              end
            end
            OP_RETAIN: begin
              if (!addr_ok_q) begin
                out_d.status = ST_INVALID;
              end else if (cnt_rd_q == CNT_MAX) begin
                out_d.status = ST_SAT;
                out_d.refs   = 16'(32'(CNT_MAX));
              end else begin
                cnt_new = cnt_rd_q + CNT_ONE;
                cnt_we  = 1'b1;
                cnt_wd  = cnt_new;
                out_d.refs = 16'(32'(cnt_new));
              end
            end
            OP_FREE: begin
              if (!addr_ok_q) begin
                out_d.status = ST_INVALID;
              end else if (cnt_rd_q == '0) begin
                out_d.status = ST_DOUBLE;
              end else begin
                cnt_new = cnt_rd_q - CNT_ONE;
                cnt_we  = 1'b1;
                cnt_wd  = cnt_new;
                out_d.refs = 16'(32'(cnt_new));
                // last reference gone: back into the queue unless it is full
                if (cnt_new == '0 && queued_q < FULL_CNT) begin
                  que_we   = 1'b1;
                  tail_d   = wrap_next(tail_q);
                  queued_d = queued_q + NW'(1);
                  out_d.page_released = 1'b1;
                end
              end
            end
            OP_QUERY: begin
              if (!addr_ok_q) begin
                out_d.status = ST_INVALID;
              end else begin
                out_d.refs = 16'(32'(cnt_rd_q));
              end
            end
            OP_INIT: begin
              state_d  = S_SWEEP;
              sweep_d  = '0;
              held_d   = held_c;
              head_d   = '0;
              queued_d = FULL_CNT - held_c;
              tail_d   = (held_c == '0) ? '0 : IW'(FULL_CNT - held_c);
            end
            default: begin
            end
          endcase
          out_d.free_page_count = 13'(queued_d);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      sweep_q     <= '0;
      held_q      <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      queued_q    <= FULL_CNT;
      out_valid_q <= 1'b0;
      base_q      <= '0;
      rsv_q       <= '0;
    end else begin
      state_q  <= state_d;
      sweep_q  <= sweep_d;
      held_q   <= held_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      queued_q <= queued_d;
      if (exec_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MEMORY_BASE:    base_q <= cfg_data_i;
          CFG_RESERVED_PAGES: rsv_q  <= cfg_data_i[12:0];
          default: begin
          end
        endcase
      end
    end
  end

  // request payload and result register
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q      <= in_data_i.op;
      idx_q     <= req_idx;
      addr_ok_q <= addr_ok;
    end
    if (exec_go) begin
      out_q <= out_d;
    end
  end

  // count memory: read on transfer, written by the sweep and at write-back
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (in_xfer) begin
      cnt_rd_q <= cnt_mem[req_idx];
    end
  end

  // free queue memory: head read on transfer, tail written on release and by the sweep
  always_ff @(posedge clk_i) begin
    if (que_we) begin
      que_mem[que_wa] <= que_wd;
    end
    if (in_xfer) begin
      que_rd_q <= que_mem[head_q];
    end
  end

  // queue occupancy never exceeds the table
  a_queued_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    queued_q <= FULL_CNT)
    else $error("free queue occupancy out of range");

  // an empty or full queue has head and tail together
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (queued_q == '0 || queued_q == FULL_CNT) |-> (head_q == tail_q))
    else $error("queue pointers disagree with occupancy");

  // the sweep never produces a result of its own
  a_sweep_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP && !(out_valid_q && out_stall_i)) |=> !out_valid_q)
    else $error("result appeared during table sweep");

endmodule
